[rtl/char_lcd_4bit_sequencer_unit_defines.svh]
// Assertion macros for the character LCD sequencer.
`ifndef CHAR_LCD_4BIT_SEQUENCER_UNIT_DEFINES_SVH
`define CHAR_LCD_4BIT_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk_i, off while in reset.
`define CLCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while in reset.
`define CLCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/clcd_pkg.sv]
// Shared types, codes and constants of the character LCD sequencer.
package clcd_pkg;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned NibW   = 4;
  localparam int unsigned HoldW  = 18;
  localparam int unsigned StrW   = 10;
  localparam int unsigned PwrW   = 18;
  localparam int unsigned HomeW  = 16;
  localparam int unsigned ClrW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 18;
  localparam int unsigned QDEPTH = 2;

  // command codes on cmd_i
  localparam logic [CmdW-1:0] CMD_INIT    = 3'd0;
  localparam logic [CmdW-1:0] CMD_CHAR    = 3'd1;
  localparam logic [CmdW-1:0] CMD_END     = 3'd2;
  localparam logic [CmdW-1:0] CMD_RAWCMD  = 3'd3;
  localparam logic [CmdW-1:0] CMD_RAWDATA = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_STROBE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_PWRUP  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_HOME   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_CLEAR  = 2'd3;

  localparam logic [StrW-1:0]  STROBE_RST = 10'd40;
  localparam logic [PwrW-1:0]  PWRUP_RST  = 18'd250000;
  localparam logic [HomeW-1:0] HOME_RST   = 16'd2000;
  localparam logic [ClrW-1:0]  CLEAR_RST  = 16'd20000;

  localparam logic [ByteW-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [ByteW-1:0] LINE_TWO_CMD = 8'hC0;
  localparam logic [ByteW-1:0] HOME_CMD     = 8'h02;
  localparam logic [NibW-1:0]  WAKE_NIB     = 4'h3;
  localparam logic [NibW-1:0]  FOUR_BIT_NIB = 4'h2;
  localparam logic [HoldW-1:0] WAKE_WAIT_1  = 18'd150000;
  localparam logic [HoldW-1:0] WAKE_WAIT_2  = 18'd200;

  // wake-up step numbers
  localparam logic [3:0] WK_LOW    = 4'd0;
  localparam logic [3:0] WK_NIB3   = 4'd1;
  localparam logic [3:0] WK_HI1    = 4'd2;
  localparam logic [3:0] WK_LO1    = 4'd3;
  localparam logic [3:0] WK_HI2    = 4'd4;
  localparam logic [3:0] WK_LO2    = 4'd5;
  localparam logic [3:0] WK_HI3    = 4'd6;
  localparam logic [3:0] WK_LO3    = 4'd7;
  localparam logic [3:0] WK_NIB2   = 4'd8;
  localparam logic [3:0] WK_HI4    = 4'd9;
  localparam logic [3:0] WK_LO4    = 4'd10;

  // byte transfer step numbers
  localparam logic [3:0] BY_RS  = 4'd0;
  localparam logic [3:0] BY_HI  = 4'd1;
  localparam logic [3:0] BY_EH1 = 4'd2;
  localparam logic [3:0] BY_EL1 = 4'd3;
  localparam logic [3:0] BY_LO  = 4'd4;
  localparam logic [3:0] BY_EH2 = 4'd5;
  localparam logic [3:0] BY_EL2 = 4'd6;

  localparam logic [1:0] INIT_LAST_IDX = 2'd3;

  typedef enum logic [1:0] {
    JOB_INIT,
    JOB_BYTE,
    JOB_END
  } job_kind_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEAD,
    PH_WAKE,
    PH_BYTE
  } phase_e;

  typedef struct packed {
    job_kind_e        kind;
    logic [ByteW-1:0] data_byte;
    logic             is_data;
  } job_t;

  typedef struct packed {
    logic            rs;
    logic            en;
    logic [NibW-1:0] db;
    logic [HoldW-1:0] hold;
    logic            last;
  } res_t;

  typedef struct packed {
    logic [StrW-1:0]  strobe;
    logic [PwrW-1:0]  pwrup;
    logic [HomeW-1:0] home;
    logic [ClrW-1:0]  clear;
  } cfg_t;

  typedef struct packed {
    logic idle;
  } back_status_t;

  function automatic logic [ByteW-1:0] init_byte(input logic [1:0] idx);
    logic [ByteW-1:0] b;
    case (idx)
      2'd0:    b = 8'h28;
      2'd1:    b = 8'h06;
      2'd2:    b = 8'h0C;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

endpackage

[rtl/clcd_front.sv]
// Front end: decodes commands into jobs and buffers them in a short queue.
module clcd_front #(
  parameter int unsigned QueueDepth = clcd_pkg::QDEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [clcd_pkg::CmdW-1:0]   cmd_i,
  input  logic [clcd_pkg::ByteW-1:0]  data_byte_i,
  output logic                        job_valid_o,
  output clcd_pkg::job_t              job_o,
  input  logic                        job_pop_i
);
  import clcd_pkg::*;

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  job_t            q_mem [QueueDepth];
  logic [IdxW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  job_t            dec_job;
  logic            dec_ok;
  logic            wr_en, rd_en;

  always_comb begin
    dec_ok            = 1'b1;
    dec_job.kind      = JOB_BYTE;
    dec_job.data_byte = data_byte_i;
    dec_job.is_data   = 1'b0;
    case (cmd_i)
      CMD_INIT: begin
        dec_job.kind = JOB_INIT;
      end
      CMD_CHAR: begin
        // newline turns into the second-line command
        if (data_byte_i == NEWLINE_CHAR) begin
          dec_job.data_byte = LINE_TWO_CMD;
        end else begin
          dec_job.is_data = 1'b1;
        end
      end
      CMD_END: begin
        dec_job.kind      = JOB_END;
        dec_job.data_byte = HOME_CMD;
      end
      CMD_RAWCMD: begin
        dec_job.is_data = 1'b0;
      end
      CMD_RAWDATA: begin
        dec_job.is_data = 1'b1;
      end
      default: begin
        dec_ok = 1'b0; // unknown command is dropped
      end
    endcase
  end

  assign full        = (count_q == FullCnt);
  assign wr_en       = push && !full && dec_ok;
  assign job_valid_o = (count_q != '0);
  assign rd_en       = job_pop_i && job_valid_o;
  assign job_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem[wr_ptr_q] <= dec_job;
    end
  end

endmodule

[rtl/clcd_back.sv]
// Back end: steps through the pin-level sequence of one job at a time, one result per step.
module clcd_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  clcd_pkg::cfg_t         cfg_i,
  input  logic                   job_valid_i,
  input  clcd_pkg::job_t         job_i,
  output logic                   job_pop_o,
  input  logic                   slot_free_i,
  output logic                   res_valid_o,
  output clcd_pkg::res_t         res_o,
  output clcd_pkg::back_status_t status_o
);
  import clcd_pkg::*;

  phase_e           phase_q, phase_d;
  logic [3:0]       step_q, step_d;
  logic [1:0]       idx_q, idx_d;
  job_kind_e        kind_q;
  logic [ByteW-1:0] byte_q;
  logic             data_q;
  logic             rs_q, en_q;
  logic [NibW-1:0]  db_q;
  logic             take, emit;
  logic [ByteW-1:0] cur_byte;
  logic             final_byte;
  logic [HomeW-1:0] tail;
  logic [HoldW-1:0] strobe;

  assign take       = (phase_q == PH_IDLE) && job_valid_i;
  assign emit       = (phase_q != PH_IDLE) && slot_free_i;
  assign job_pop_o  = take;
  assign res_valid_o = emit;
  assign status_o.idle = (phase_q == PH_IDLE);

  assign cur_byte   = (kind_q == JOB_INIT) ? init_byte(idx_q) : byte_q;
  assign final_byte = (kind_q != JOB_INIT) || (idx_q == INIT_LAST_IDX);
  assign strobe     = HoldW'(cfg_i.strobe);

  always_comb begin
    case (kind_q)
      JOB_INIT: tail = final_byte ? cfg_i.clear : '0;
      JOB_END:  tail = cfg_i.home;
      default:  tail = '0;
    endcase
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    idx_d   = idx_q;
    case (phase_q)
      PH_IDLE: begin
        if (take) begin
          step_d  = '0;
          idx_d   = '0;
          phase_d = (job_i.kind == JOB_BYTE) ? PH_BYTE : PH_LEAD;
        end
      end
      PH_LEAD: begin
        if (emit) begin
          phase_d = (kind_q == JOB_INIT) ? PH_WAKE : PH_BYTE;
          step_d  = '0;
        end
      end
      PH_WAKE: begin
        if (emit) begin
          if (step_q == WK_LO4) begin
            phase_d = PH_BYTE;
            step_d  = '0;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      PH_BYTE: begin
        if (emit) begin
          if (step_q == BY_EL2) begin
            step_d = '0;
            if (final_byte) begin
              phase_d = PH_IDLE;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // result of the current step
  always_comb begin
    res_o.rs   = rs_q;
    res_o.en   = en_q;
    res_o.db   = db_q;
    res_o.hold = '0;
    res_o.last = 1'b0;
    case (phase_q)
      PH_LEAD: begin
        res_o.hold = (kind_q == JOB_INIT) ? HoldW'(cfg_i.pwrup) : HoldW'(cfg_i.home);
      end
      PH_WAKE: begin
        case (step_q)
          WK_LOW: begin
            res_o.rs = 1'b0;
            res_o.en = 1'b0;
          end
          WK_NIB3: res_o.db = WAKE_NIB;
          WK_HI1, WK_HI2, WK_HI3: res_o.en = 1'b1;
          WK_LO1: begin
            res_o.en   = 1'b0;
            res_o.hold = WAKE_WAIT_1;
          end
          WK_LO2, WK_LO3: begin
            res_o.en   = 1'b0;
            res_o.hold = WAKE_WAIT_2;
          end
          WK_NIB2: begin
            res_o.db   = FOUR_BIT_NIB;
            res_o.hold = strobe;
          end
          WK_HI4: begin
            res_o.en   = 1'b1;
            res_o.hold = strobe;
          end
          default: res_o.en = 1'b0;
        endcase
      end
      PH_BYTE: begin
        case (step_q)
          BY_RS: begin
            res_o.rs   = data_q && (kind_q == JOB_BYTE);
            res_o.hold = strobe;
          end
          BY_HI: res_o.db = cur_byte[ByteW-1:NibW];
          BY_EH1, BY_EH2: begin
            res_o.en   = 1'b1;
            res_o.hold = strobe;
          end
          BY_EL1: begin
            res_o.en   = 1'b0;
            res_o.hold = strobe;
          end
          BY_LO: res_o.db = cur_byte[NibW-1:0];
          default: begin
            res_o.en   = 1'b0;
            res_o.hold = strobe + HoldW'(tail);
            res_o.last = final_byte;
          end
        endcase
      end
      default: res_o.hold = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      step_q  <= '0;
      idx_q   <= '0;
      kind_q  <= JOB_BYTE;
      rs_q    <= 1'b0;
      en_q    <= 1'b0;
      db_q    <= '0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
      idx_q   <= idx_d;
      if (take) begin
        kind_q <= job_i.kind;
      end
      if (emit) begin
        rs_q <= res_o.rs;
        en_q <= res_o.en;
        db_q <= res_o.db;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= job_i.data_byte;
      data_q <= job_i.is_data;
    end
  end

endmodule

[rtl/char_lcd_4bit_sequencer_unit.sv]
// Top level of the 4-bit character LCD sequencer.
//
//  channel   | handshake       | payload
//  ----------+-----------------+-------------------------------------------
//  command   | push / full     | cmd_i, data_byte_i
//  result    | pop / empty     | rs_line_o, en_line_o, db_lines_o, hold_us_o, last_o
//  config    | cfg_we_i        | cfg_idx_i, cfg_wdata_i
//
// The back end takes a queued job while idle, then delivers one result per
// cycle while pop keeps up. The output register sets the pace.
// Reset restores the register defaults; the output result register is not reset.
// A full result register stalls the sequencer; a full job queue raises full.
module char_lcd_4bit_sequencer_unit #(
  parameter int unsigned QueueDepth = clcd_pkg::QDEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [clcd_pkg::CmdW-1:0]     cmd_i,
  input  logic [clcd_pkg::ByteW-1:0]    data_byte_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          rs_line_o,
  output logic                          en_line_o,
  output logic [clcd_pkg::NibW-1:0]     db_lines_o,
  output logic [clcd_pkg::HoldW-1:0]    hold_us_o,
  output logic                          last_o,
  input  logic                          cfg_we_i,
  input  logic [clcd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [clcd_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import clcd_pkg::*;

`include "char_lcd_4bit_sequencer_unit_defines.svh"

  cfg_t         cfg_q;
  job_t         job;
  logic         job_valid, job_pop;
  res_t         res_d, res_q;
  logic         res_load, res_valid_q;
  logic         slot_free;
  back_status_t back_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.strobe <= STROBE_RST;
      cfg_q.pwrup  <= PWRUP_RST;
      cfg_q.home   <= HOME_RST;
      cfg_q.clear  <= CLEAR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STROBE: cfg_q.strobe <= cfg_wdata_i[StrW-1:0];
        REG_PWRUP:  cfg_q.pwrup  <= cfg_wdata_i[PwrW-1:0];
        REG_HOME:   cfg_q.home   <= cfg_wdata_i[HomeW-1:0];
        REG_CLEAR:  cfg_q.clear  <= cfg_wdata_i[ClrW-1:0];
        default:    cfg_q        <= cfg_q;
      endcase
    end
  end

  clcd_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .cmd_i       (cmd_i),
    .data_byte_i (data_byte_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  assign slot_free = !res_valid_q || pop;

  clcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .slot_free_i (slot_free),
    .res_valid_o (res_load),
    .res_o       (res_d),
    .status_o    (back_status)
  );

  // output register, refilled in the cycle the old result transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (pop) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign empty      = !res_valid_q;
  assign rs_line_o  = res_q.rs;
  assign en_line_o  = res_q.en;
  assign db_lines_o = res_q.db;
  assign hold_us_o  = res_q.hold;
  assign last_o     = res_q.last;

  `CLCD_ASSERT_NXT(a_last_goes_idle, res_load && res_d.last, back_status.idle, "sequencer busy after last result")
  `CLCD_ASSERT_IMP(a_last_en_low, res_load && res_d.last, !res_d.en, "run ends with enable high")
  `CLCD_ASSERT_IMP(a_en_hold, res_load && res_d.en, (res_d.hold == HoldW'(cfg_q.strobe)) || (res_d.hold == '0), "bad enable-high hold")

endmodule

[dv/char_lcd_4bit_sequencer_unit_tb.sv]
// Testbench of the 4-bit character LCD sequencer: directed and random commands.
`timescale 1ns / 100ps

module char_lcd_4bit_sequencer_unit_tb;
  import clcd_pkg::*;

  class lcd_pin_scoreboard;
    res_t             pin_steps_q[$];
    logic [StrW-1:0]  strobe_us;
    logic [PwrW-1:0]  pwrup_us;
    logic [HomeW-1:0] home_us;
    logic [ClrW-1:0]  clear_us;
    logic             rs_lvl;
    logic             en_lvl;
    logic [NibW-1:0]  db_lvl;
    int unsigned      errors;

    function new();
      strobe_us = STROBE_RST;
      pwrup_us  = PWRUP_RST;
      home_us   = HOME_RST;
      clear_us  = CLEAR_RST;
      rs_lvl    = 1'b0;
      en_lvl    = 1'b0;
      db_lvl    = '0;
      errors    = 0;
    endfunction

    function int pending();
      return pin_steps_q.size();
    endfunction

    function void set_reg(input logic [CfgIdxW-1:0] idx,
                          input logic [CfgDataW-1:0] val);
      case (idx)
        REG_STROBE: strobe_us = val[StrW-1:0];
        REG_PWRUP:  pwrup_us  = val[PwrW-1:0];
        REG_HOME:   home_us   = val[HomeW-1:0];
        REG_CLEAR:  clear_us  = val[ClrW-1:0];
        default: ;
      endcase
    endfunction

    function void add_level(input logic [HoldW-1:0] hold);
      res_t r;
      r.rs   = rs_lvl;
      r.en   = en_lvl;
      r.db   = db_lvl;
      r.hold = hold;
      r.last = 1'b0;
      pin_steps_q.push_back(r);
    endfunction

    function void add_en_pulse(input logic [HoldW-1:0] hi_hold,
                               input logic [HoldW-1:0] lo_hold);
      en_lvl = 1'b1;
      add_level(hi_hold);
      en_lvl = 1'b0;
      add_level(lo_hold);
    endfunction

    // seven pin steps per byte, high nibble first
    function void add_byte(input logic [ByteW-1:0] b, input logic is_data,
                           input logic [HoldW-1:0] tail);
      logic [HoldW-1:0] s;
      s = HoldW'(strobe_us);
      rs_lvl = is_data;
      add_level(s);
      db_lvl = b[7:4];
      add_level('0);
      add_en_pulse(s, s);
      db_lvl = b[3:0];
      add_level('0);
      add_en_pulse(s, s + tail);
    endfunction

    function void note_command(input logic [CmdW-1:0] c, input logic [ByteW-1:0] b);
      logic [ByteW-1:0] setup_bytes [4];
      int               first;
      res_t             tail_step;
      setup_bytes = '{8'h28, 8'h06, 8'h0C, 8'h01};
      first = pin_steps_q.size();
      case (c)
        CMD_INIT: begin
          add_level(HoldW'(pwrup_us));
          en_lvl = 1'b0;
          rs_lvl = 1'b0;
          add_level('0);
          db_lvl = WAKE_NIB;
          add_level('0);
          add_en_pulse('0, WAKE_WAIT_1);
          add_en_pulse('0, WAKE_WAIT_2);
          add_en_pulse('0, WAKE_WAIT_2);
          db_lvl = FOUR_BIT_NIB;
          add_level(HoldW'(strobe_us));
          add_en_pulse(HoldW'(strobe_us), '0);
          for (int k = 0; k < 4; k++)
            add_byte(setup_bytes[k], 1'b0, (k == 3) ? HoldW'(clear_us) : '0);
        end
        CMD_CHAR: begin
          if (b == NEWLINE_CHAR) add_byte(LINE_TWO_CMD, 1'b0, '0);
          else add_byte(b, 1'b1, '0);
        end
        CMD_END: begin
          add_level(HoldW'(home_us));
          add_byte(HOME_CMD, 1'b0, HoldW'(home_us));
        end
        CMD_RAWCMD:  add_byte(b, 1'b0, '0);
        CMD_RAWDATA: add_byte(b, 1'b1, '0);
        default: ;  // unused codes are dropped without output
      endcase
      if (pin_steps_q.size() > first) begin
        tail_step = pin_steps_q.pop_back();
        tail_step.last = 1'b1;
        pin_steps_q.push_back(tail_step);
      end
    endfunction

    function void check_result(input logic rs, input logic en, input logic [NibW-1:0] db,
                               input logic [HoldW-1:0] hold, input logic last);
      res_t e;
      if (pin_steps_q.size() == 0) begin
        $error("unexpected result: rs %0d en %0d db 0x%0h hold %0d last %0d",
               rs, en, db, hold, last);
        errors++;
        return;
      end
      e = pin_steps_q.pop_front();
      if (rs !== e.rs) begin
        $error("rs_line: expected %0d, got %0d", e.rs, rs);
        errors++;
      end
      if (en !== e.en) begin
        $error("en_line: expected %0d, got %0d", e.en, en);
        errors++;
      end
      if (db !== e.db) begin
        $error("db_lines: expected 0x%0h, got 0x%0h", e.db, db);
        errors++;
      end
      if (hold !== e.hold) begin
        $error("hold_us: expected %0d, got %0d", e.hold, hold);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  localparam int unsigned    SETTLE_CYCLES  = 64;
  localparam int unsigned    CYCLE_LIMIT    = 600000;
  localparam int unsigned    RAND_PHASES    = 6;
  localparam int unsigned    PHASE_ITEMS    = 50;
  localparam logic [CmdW-1:0] CMD_UNUSED_MIN = CMD_RAWDATA + 3'd1;
  localparam logic [CmdW-1:0] CMD_UNUSED_MAX = '1;

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  logic [CmdW-1:0]     cmd;
  logic [ByteW-1:0]    data_byte;
  logic                empty;
  logic                pop;
  logic                rs_line;
  logic                en_line;
  logic [NibW-1:0]     db_lines;
  logic [HoldW-1:0]    hold_us;
  logic                last;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  int unsigned         tx_idle_pct;
  int unsigned         rx_idle_pct;
  int unsigned         cycles;
  lcd_pin_scoreboard   sb;

  char_lcd_4bit_sequencer_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .cmd_i       (cmd),
    .data_byte_i (data_byte),
    .empty       (empty),
    .pop         (pop),
    .rs_line_o   (rs_line),
    .en_line_o   (en_line),
    .db_lines_o  (db_lines),
    .hold_us_o   (hold_us),
    .last_o      (last),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // result side: random pop, check every transfer
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      @(posedge clk_i);
      if (rst_ni && pop && !empty)
        sb.check_result(rs_line, en_line, db_lines, hold_us, last);
    end
  end

  task automatic push_command(input logic [CmdW-1:0] c, input logic [ByteW-1:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push      <= 1'b1;
    cmd       <= c;
    data_byte <= b;
    do @(posedge clk_i); while (full);
    sb.note_command(c, b);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // ignored commands leave no trace, so drain the results and then let the design settle
  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [CfgDataW-1:0] v_strobe,
                            input logic [CfgDataW-1:0] v_pwrup,
                            input logic [CfgDataW-1:0] v_home,
                            input logic [CfgDataW-1:0] v_clear);
    logic [CfgIdxW-1:0]  idx [4];
    logic [CfgDataW-1:0] vals [4];
    idx  = '{REG_STROBE, REG_PWRUP, REG_HOME, REG_CLEAR};
    vals = '{v_strobe, v_pwrup, v_home, v_clear};
    for (int k = 0; k < 4; k++) begin
      @(negedge clk_i);
      cfg_we    <= 1'b1;
      cfg_idx   <= idx[k];
      cfg_wdata <= vals[k];
      sb.set_reg(idx[k], vals[k]);
    end
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic push_random_command();
    int unsigned      pick;
    logic [CmdW-1:0]  c;
    logic [ByteW-1:0] b;
    pick = $urandom_range(0, 99);
    b    = ByteW'($urandom_range(0, 255));
    if (pick < 8) c = CMD_INIT;
    else if (pick < 40) begin
      c = CMD_CHAR;
      if ($urandom_range(0, 6) == 0) b = NEWLINE_CHAR;
    end
    else if (pick < 52) c = CMD_END;
    else if (pick < 70) c = CMD_RAWCMD;
    else if (pick < 90) c = CMD_RAWDATA;
    else c = CmdW'($urandom_range(int'(CMD_UNUSED_MIN), int'(CMD_UNUSED_MAX)));
    push_command(c, b);
  endtask

  initial begin
    sb          = new();
    tx_idle_pct = 28;
    rx_idle_pct = 71;
    rst_ni      = 1'b0;
    push        = 1'b0;
    cmd         = CMD_INIT;
    data_byte   = '0;
    cfg_we      = 1'b0;
    cfg_idx     = REG_STROBE;
    cfg_wdata   = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: register defaults, every command, newline, unused codes
    push_command(CMD_CHAR, 8'h41);      // before any power-up, lines at reset levels
    push_command(CMD_INIT, 8'hFF);
    push_command(CMD_CHAR, 8'h00);
    push_command(CMD_CHAR, 8'hFF);
    push_command(CMD_CHAR, NEWLINE_CHAR);
    push_command(CMD_CHAR, 8'h0B);
    push_command(CMD_END, 8'h00);
    push_command(CMD_RAWCMD, 8'h00);
    push_command(CMD_RAWCMD, 8'hFF);
    push_command(CMD_RAWCMD, NEWLINE_CHAR);
    push_command(CMD_RAWDATA, 8'hAA);
    push_command(CMD_RAWDATA, 8'h55);
    push_command(CMD_UNUSED_MIN, 8'h12);
    push_command(CMD_UNUSED_MIN + 3'd1, 8'hFF);
    push_command(CMD_UNUSED_MAX, 8'h00);
    push_command(CMD_END, 8'hFF);
    push_command(CMD_END, 8'h5A);
    push_command(CMD_INIT, 8'h00);
    push_command(CMD_RAWDATA, 8'h0F);
    push_command(CMD_RAWDATA, 8'hF0);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      tx_idle_pct = (ph < 2) ? 28 : ((ph < 4) ? 71 : 0);
      rx_idle_pct = (ph < 2) ? 71 : ((ph < 4) ? 28 : 0);
      settle();
      case (ph)
        0: write_regs(18'd1, 18'd0, 18'd0, 18'd0);
        1: write_regs(18'd1023, 18'd262143, 18'd65535, 18'd65535);
        // full-width data also checks masking to the register width
        default: write_regs(CfgDataW'($urandom()), CfgDataW'($urandom()),
                            CfgDataW'($urandom()), CfgDataW'($urandom()));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) drain_results();
        push_random_command();
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
